// File: sv/gfg_pkg.sv
// ----------------------------------------------------------------------------
// gfg_pkg
// Types and constants of the GPU frequency governor: payload structs,
// register indexes, reset values, sample classes and sequencer states.
// ----------------------------------------------------------------------------
package gfg_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FREQ_W     = 20;
  localparam int MUL_W      = 17;
  localparam int DIV_W      = 33;
  localparam int DIV_CNT_W  = 6;
  localparam int CNT_W      = 32;

  // bias divide by 50: quotient of a 23-bit product through a reciprocal
  localparam int BNUM_W   = 23;
  localparam int BQ_W     = 17;
  localparam int RECIP_W  = 24;
  localparam int RECIP_SH = 29;
  localparam logic [RECIP_W-1:0] RECIP_50 = 24'd10737419;

  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_EFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EPB      = 2'd3;

  localparam logic [15:0] RST_FREQ_MAX = 16'd2000;
  localparam logic [15:0] RST_FREQ_EFF = 16'd1400;
  localparam logic [15:0] RST_FREQ_MIN = 16'd800;
  localparam logic [6:0]  RST_EPB      = 7'd50;
  localparam logic [6:0]  BIAS_MID     = 7'd50;

  localparam logic [MUL_W-1:0] Q_ONE = 17'h10000;

  typedef struct packed {
    logic [2:0]  gpu_index;
    logic        util_valid;
    logic [16:0] utilization;
    logic        sm_valid;
    logic [16:0] sm_activity;
  } gfg_in_t;

  typedef struct packed {
    logic [2:0]       gpu_number;
    logic [15:0]      frequency_request;
    logic             write_control;
    logic [1:0]       sample_class;
    logic [CNT_W-1:0] write_count;
    logic [CNT_W-1:0] low_count;
    logic [CNT_W-1:0] high_count;
    logic [CNT_W-1:0] sm_low_count;
  } gfg_out_t;

  typedef enum logic [1:0] {
    CLS_ACTIVE  = 2'd0,
    CLS_SM_IDLE = 2'd1,
    CLS_IDLE    = 2'd2,
    CLS_NO_UTIL = 2'd3
  } gfg_cls_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BIAS_DIV,
    ST_BIAS_ADJ,
    ST_WIN_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DECIDE,
    ST_RATIO_WAIT,
    ST_SCALE_MUL,
    ST_SCALE_ADD,
    ST_FINISH
  } gfg_state_e;

endpackage

// File: sv/gpu_frequency_governor.sv
// ----------------------------------------------------------------------------
// gpu_frequency_governor
// Per-GPU clock governor: turns one utilization / SM activity sample into a
// clamped frequency request with a write flag and saturating statistics.
// ----------------------------------------------------------------------------
// One item is worked at a time under a small sequencer around one shared
// 17x17 multiplier and one bit-serial 33-bit divider; the bias divide by 50
// is a constant reciprocal multiply. An accepted item is loaded, passes the
// reciprocal step when the bias is not 50 and is bias adjusted. With a valid
// utilization its window entry is written, the window is scanned until a
// nonzero entry is found or no filled entry is left, the ratio divide runs
// when the window is active with a valid SM value and a nonzero utilization,
// and the scaling multiply follows whenever an SM value sets the request.
// The divider gives one quotient bit per cycle. The next item is taken in the
// cycle after the result is registered. Items for a GPU index not below
// NUM_GPUS are accepted and dropped without a result. The result sits in an
// output register, so a new item is taken while it waits. The window store
// needs no clearing pass: a per-GPU fill count masks entries never written.
// ----------------------------------------------------------------------------
module gpu_frequency_governor import gfg_pkg::*; #(
  parameter int NUM_GPUS       = 8,
  parameter int WINDOW_SAMPLES = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  gfg_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gfg_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int GW    = (NUM_GPUS > 1) ? $clog2(NUM_GPUS) : 1;
  localparam int PW    = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int FW    = $clog2(WINDOW_SAMPLES + 1);
  localparam int DEPTH = NUM_GPUS * WINDOW_SAMPLES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = 16 + PW + FW;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  gfg_state_e state_q, state_d;

  logic [15:0] fmax_cfg_q, feff_cfg_q, fmin_cfg_q;
  logic [6:0]  epb_q;

  gfg_in_t in_q;
  logic signed [FREQ_W-1:0] fmax_q, feff_q, range_q, req_q;
  logic [2*MUL_W-1:0] prod_q;
  logic [MUL_W-1:0]   r_q;
  logic [BQ_W-1:0]    bq_q;
  gfg_cls_e           cls_q;

  logic [DIV_W-1:0]     div_num_q;
  logic [MUL_W-1:0]     div_den_q;
  logic [MUL_W-1:0]     div_rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  logic [EW-1:0]       ent_mem [NUM_GPUS];
  logic [EW-1:0]       ent_rd_q;
  logic [NUM_GPUS-1:0] ent_valid_q;
  logic                seen_q;
  logic [15:0]         last_q;
  logic [PW-1:0]       ptr_q;
  logic [FW-1:0]       fill_q, idx_q;
  logic                any_q;

  logic [MUL_W-1:0] win_mem [DEPTH];
  logic [MUL_W-1:0] win_rd_q;

  logic [CNT_W-1:0] cnt_wr_q, cnt_low_q, cnt_high_q, cnt_smlow_q;
  logic [CNT_W-1:0] cnt_wr_d, cnt_low_d, cnt_high_d, cnt_smlow_d;

  gfg_out_t out_q;
  logic     out_valid_q;

  logic                      gpu_ok, div_start, commit;
  logic [GW-1:0]             gsel;
  logic [AW-1:0]             base;
  logic signed [FREQ_W-1:0]  range_abs, fmin_s, q_s, sq, t_s, fmax_n, feff_n;
  logic signed [FREQ_W-1:0]  ds, req_scaled, c1, c2, c3;
  logic [6:0]                bias_k;
  logic [MUL_W-1:0]          mul_a, mul_b, m_val, r_cap;
  logic [2*MUL_W-1:0]        mul_p;
  logic [BNUM_W+RECIP_W-1:0] bias_p;
  logic [MUL_W:0]            rem_sh, rem_n;
  logic                      rem_ge;
  logic [PW-1:0]             ptr_n;
  logic [FW-1:0]             fill_n;
  logic [15:0]               r16;
  logic                      wr;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign gpu_ok = (32'(in_data_i.gpu_index) < NUM_GPUS);
  assign gsel   = GW'(in_q.gpu_index);
  assign base   = AW'(gsel) * AW'(WINDOW_SAMPLES);
  assign fmin_s = signed'({4'b0, fmin_cfg_q});

  // shared multiplier
  assign range_abs = range_q[FREQ_W-1] ? -range_q : range_q;
  assign bias_k    = (epb_q > BIAS_MID) ? epb_q - BIAS_MID : BIAS_MID - epb_q;
  assign mul_a     = range_abs[MUL_W-1:0];
  assign mul_b     = (state_q == ST_LOAD) ? MUL_W'(bias_k) : r_q;
  assign mul_p     = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

  // divide the bias product by 50
  assign bias_p = (BNUM_W+RECIP_W)'(prod_q[BNUM_W-1:0]) * (BNUM_W+RECIP_W)'(RECIP_50);

  // restoring divider step
  assign rem_sh = {div_rem_q, div_num_q[DIV_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_den_q});
  assign rem_n  = rem_ge ? rem_sh - {1'b0, div_den_q} : rem_sh;

  // bias adjust
  always_comb begin
    q_s    = signed'(FREQ_W'(bq_q));
    sq     = range_q[FREQ_W-1] ? -q_s : q_s;
    fmax_n = fmax_q;
    feff_n = feff_q;
    t_s    = fmax_q - sq;
    if (epb_q > BIAS_MID) begin
      fmax_n = (t_s > feff_q) ? t_s : feff_q;
    end else if (epb_q < BIAS_MID) begin
      t_s    = feff_q + sq;
      feff_n = (t_s < fmax_q) ? t_s : fmax_q;
    end
  end

  assign m_val = (in_q.sm_activity < in_q.utilization) ? in_q.sm_activity : in_q.utilization;
  assign r_cap = (in_q.sm_activity > Q_ONE) ? Q_ONE : in_q.sm_activity;

  assign ds         = signed'({2'b0, prod_q[2*MUL_W-1:16]});
  assign req_scaled = range_q[FREQ_W-1] ? feff_q - ds : feff_q + ds;

  assign ptr_n  = (ptr_q == PW'(WINDOW_SAMPLES - 1)) ? '0 : ptr_q + 1'b1;
  assign fill_n = (fill_q == FW'(WINDOW_SAMPLES)) ? fill_q : fill_q + 1'b1;

  // clamp and compare
  always_comb begin
    c1  = (req_q > fmax_q) ? fmax_q : req_q;
    c2  = (c1 < fmin_s) ? fmin_s : c1;
    c3  = (c2 > signed'(FREQ_W'(16'hFFFF))) ? signed'(FREQ_W'(16'hFFFF)) : c2;
    if (c3 < 0) begin
      c3 = '0;
    end
    r16 = c3[15:0];
    wr  = !seen_q || (last_q != r16);
  end

  always_comb begin
    cnt_wr_d    = wr ? sat_inc(cnt_wr_q) : cnt_wr_q;
    cnt_high_d  = (cls_q == CLS_ACTIVE) ? sat_inc(cnt_high_q) : cnt_high_q;
    cnt_low_d   = (cls_q == CLS_SM_IDLE || cls_q == CLS_IDLE) ?
                  sat_inc(cnt_low_q) : cnt_low_q;
    cnt_smlow_d = (cls_q == CLS_SM_IDLE) ? sat_inc(cnt_smlow_q) : cnt_smlow_q;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    commit    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && gpu_ok) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = (epb_q == BIAS_MID) ? ST_BIAS_ADJ : ST_BIAS_DIV;
      end
      ST_BIAS_DIV: begin
        state_d = ST_BIAS_ADJ;
      end
      ST_BIAS_ADJ: begin
        state_d = in_q.util_valid ? ST_WIN_WR : ST_FINISH;
      end
      ST_WIN_WR: begin
        state_d = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        state_d = (any_q || idx_q >= fill_q) ? ST_DECIDE : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        state_d = ST_SCAN_RD;
      end
      ST_DECIDE: begin
        if (any_q) begin
          if (!in_q.sm_valid) begin
            state_d = ST_FINISH;
          end else if (in_q.utilization != '0) begin
            div_start = 1'b1;
            state_d   = ST_RATIO_WAIT;
          end else begin
            state_d = ST_SCALE_MUL;
          end
        end else if (in_q.sm_valid && in_q.sm_activity != '0) begin
          state_d = ST_SCALE_MUL;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_RATIO_WAIT: begin
        if (div_cnt_q == '0) begin
          state_d = ST_SCALE_MUL;
        end
      end
      ST_SCALE_MUL: begin
        state_d = ST_SCALE_ADD;
      end
      ST_SCALE_ADD: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!(out_valid_q && out_stall_i)) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fmax_cfg_q  <= RST_FREQ_MAX;
      feff_cfg_q  <= RST_FREQ_EFF;
      fmin_cfg_q  <= RST_FREQ_MIN;
      epb_q       <= RST_EPB;
      ent_valid_q <= '0;
      div_cnt_q   <= '0;
      cnt_wr_q    <= '0;
      cnt_low_q   <= '0;
      cnt_high_q  <= '0;
      cnt_smlow_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FREQ_MAX: fmax_cfg_q <= cfg_data_i;
          CFG_FREQ_EFF: feff_cfg_q <= cfg_data_i;
          CFG_FREQ_MIN: fmin_cfg_q <= cfg_data_i;
          CFG_EPB:      epb_q      <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (div_start) begin
        div_cnt_q <= DIV_CNT_W'(DIV_W);
      end else if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - 1'b1;
      end
      if (commit) begin
        ent_valid_q[gsel] <= 1'b1;
        cnt_wr_q          <= cnt_wr_d;
        cnt_low_q         <= cnt_low_d;
        cnt_high_q        <= cnt_high_d;
        cnt_smlow_q       <= cnt_smlow_d;
        out_valid_q       <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_num_q <= {m_val, 16'b0};
      div_den_q <= in_q.utilization;
      div_rem_q <= '0;
    end else if (div_cnt_q != '0) begin
      div_num_q <= {div_num_q[DIV_W-2:0], rem_ge};
      div_rem_q <= rem_n[MUL_W-1:0];
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_q    <= in_data_i;
          fmax_q  <= signed'({4'b0, fmax_cfg_q});
          feff_q  <= signed'({4'b0, feff_cfg_q});
          range_q <= signed'({4'b0, fmax_cfg_q}) - signed'({4'b0, feff_cfg_q});
        end
      end
      ST_LOAD: begin
        prod_q   <= mul_p;
        ent_rd_q <= ent_mem[gsel];
      end
      ST_BIAS_DIV: begin
        bq_q <= bias_p[RECIP_SH +: BQ_W];
      end
      ST_BIAS_ADJ: begin
        fmax_q  <= fmax_n;
        feff_q  <= feff_n;
        range_q <= fmax_n - feff_n;
        req_q   <= fmax_n;
        cls_q   <= CLS_NO_UTIL;
        seen_q  <= ent_valid_q[gsel];
        last_q  <= ent_rd_q[EW-1 -: 16];
        ptr_q   <= ent_valid_q[gsel] ? ent_rd_q[FW +: PW] : '0;
        fill_q  <= ent_valid_q[gsel] ? ent_rd_q[FW-1:0] : '0;
      end
      ST_WIN_WR: begin
        win_mem[base + AW'(ptr_q)] <= in_q.utilization;
        ptr_q  <= ptr_n;
        fill_q <= fill_n;
        any_q  <= (in_q.utilization != '0);
        idx_q  <= '0;
      end
      ST_SCAN_RD: begin
        if (!any_q && idx_q < fill_q) begin
          win_rd_q <= win_mem[base + AW'(idx_q[PW-1:0])];
        end
      end
      ST_SCAN_CHK: begin
        if (win_rd_q != '0) begin
          any_q <= 1'b1;
        end
        idx_q <= idx_q + 1'b1;
      end
      ST_DECIDE: begin
        r_q <= r_cap;
        if (any_q) begin
          cls_q <= CLS_ACTIVE;
        end else if (in_q.sm_valid && in_q.sm_activity != '0) begin
          cls_q <= CLS_SM_IDLE;
        end else begin
          cls_q <= CLS_IDLE;
          req_q <= fmin_s;
        end
      end
      ST_RATIO_WAIT: begin
        if (div_cnt_q == '0) begin
          r_q <= div_num_q[MUL_W-1:0];
        end
      end
      ST_SCALE_MUL: begin
        prod_q <= mul_p;
      end
      ST_SCALE_ADD: begin
        req_q <= req_scaled;
      end
      ST_FINISH: begin
        if (commit) begin
          ent_mem[gsel]           <= {r16, ptr_q, fill_q};
          out_q.gpu_number        <= in_q.gpu_index;
          out_q.frequency_request <= r16;
          out_q.write_control     <= wr;
          out_q.sample_class      <= 2'(cls_q);
          out_q.write_count       <= cnt_wr_d;
          out_q.low_count         <= cnt_low_d;
          out_q.high_count        <= cnt_high_d;
          out_q.sm_low_count      <= cnt_smlow_d;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: bench/gpu_frequency_governor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpu_frequency_governor_tb
// Self-checking bench for the GPU frequency governor. A queue of samples feeds
// a clocked driver with random gaps, and a clocked monitor with random stalls
// checks every request against a predictor that tracks the per-GPU windows,
// last settings and counters. Directed samples run first, then phases of
// random sample runs under reset, fixed corner and random register settings.
// ----------------------------------------------------------------------------
module gpu_frequency_governor_tb;
  import gfg_pkg::*;

  localparam int NGPU        = 8;
  localparam int WIN         = 5;
  localparam int Q16_ONE     = 65536;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int TAIL_CYCLES = 200;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int NUM_PHASES  = 12;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  gfg_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  gfg_out_t              out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  gpu_frequency_governor #(
    .NUM_GPUS      (NGPU),
    .WINDOW_SAMPLES(WIN)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // governor state mirror
  logic [15:0] gov_max  = RST_FREQ_MAX;
  logic [15:0] gov_eff  = RST_FREQ_EFF;
  logic [15:0] gov_min  = RST_FREQ_MIN;
  logic [6:0]  gov_bias = RST_EPB;
  logic [16:0] util_hist [NGPU][WIN];
  int          hist_ptr [NGPU];
  logic [15:0] last_freq [NGPU];
  logic        freq_written [NGPU];
  logic [31:0] writes_cnt, low_cnt, high_cnt, sm_low_cnt;

  gfg_in_t  sample_queue [$];
  gfg_out_t pending_requests [$];

  int  send_gap = 0;
  int  stall_hold = 0;
  bit  no_idle = 1'b0;
  int  cycle_count = 0;
  int  errors = 0;
  int  samples_sent = 0;
  int  results_seen = 0;
  int  freq_writes_seen = 0;
  int  phases_run = 0;
  int  class_seen [4];

  int unsigned fix_max  [6] = '{65535, 65535,     0, 1000,  800, 0};
  int unsigned fix_eff  [6] = '{    0, 65535, 65535, 1500, 1400, 0};
  int unsigned fix_min  [6] = '{    0, 65535,     0, 1200, 2000, 0};
  int unsigned fix_bias [6] = '{    0,   100,   127,   75,   20, 50};

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  function automatic gfg_out_t govern_sample(gfg_in_t s);
    gfg_out_t o;
    longint   fmax, feff, fmin, bias, span, req, t, r, m, util, sm;
    int       g, p;
    bit       active;
    logic [15:0] f16;
    gfg_cls_e cls;
    g = s.gpu_index;
    util = s.utilization;
    sm = s.sm_activity;
    fmax = gov_max;
    feff = gov_eff;
    fmin = gov_min;
    bias = gov_bias;
    span = fmax - feff;
    if (bias > 50) begin
      t = fmax - span * (bias - 50) / 50;
      fmax = (t > feff) ? t : feff;
    end else if (bias < 50) begin
      t = feff + span * (50 - bias) / 50;
      feff = (t < fmax) ? t : fmax;
    end
    span = fmax - feff;
    req = fmax;
    active = 1'b0;
    if (!s.util_valid) begin
      cls = CLS_NO_UTIL;
    end else begin
      p = hist_ptr[g];
      util_hist[g][p] = s.utilization;
      hist_ptr[g] = (p + 1 >= WIN) ? 0 : p + 1;
      for (int i = 0; i < WIN; i++)
        if (util_hist[g][i] != 0) active = 1'b1;
      if (active) begin
        if (s.sm_valid) begin
          if (util != 0) begin
            m = (sm < util) ? sm : util;
            r = m * Q16_ONE / util;
          end else begin
            r = (sm < Q16_ONE) ? sm : Q16_ONE;
          end
          req = feff + span * r / Q16_ONE;
        end
        cls = CLS_ACTIVE;
        high_cnt = sat_inc(high_cnt);
      end else if (s.sm_valid && sm != 0) begin
        r = (sm < Q16_ONE) ? sm : Q16_ONE;
        req = feff + span * r / Q16_ONE;
        cls = CLS_SM_IDLE;
        sm_low_cnt = sat_inc(sm_low_cnt);
        low_cnt = sat_inc(low_cnt);
      end else begin
        req = fmin;
        cls = CLS_IDLE;
        low_cnt = sat_inc(low_cnt);
      end
    end
    if (req > fmax) req = fmax;
    if (req < fmin) req = fmin;
    if (req > 65535) req = 65535;
    if (req < 0) req = 0;
    f16 = req[15:0];
    o.write_control = !freq_written[g] || last_freq[g] != f16;
    if (o.write_control) begin
      last_freq[g] = f16;
      freq_written[g] = 1'b1;
      writes_cnt = sat_inc(writes_cnt);
    end
    o.gpu_number = s.gpu_index;
    o.frequency_request = f16;
    o.sample_class = cls;
    o.write_count = writes_cnt;
    o.low_count = low_cnt;
    o.high_count = high_cnt;
    o.sm_low_count = sm_low_cnt;
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      if (errors < 30)
        $display("[%0t] result %0d: %s is 0x%0h, predicted 0x%0h",
                 $realtime, results_seen, field, got, want);
      errors++;
    end
  endtask

  function automatic logic [16:0] rand_q16();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'd65535;
      3: return 17'($urandom_range(1, 255));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic push_sample(int g, bit uv, int unsigned u, bit sv, int unsigned s);
    gfg_in_t it;
    it.gpu_index = g[2:0];
    it.util_valid = uv;
    it.utilization = u[16:0];
    it.sm_valid = sv;
    it.sm_activity = s[16:0];
    sample_queue.insert(sample_queue.size(), it);
  endtask

  task automatic add_random_samples(int n);
    int added, g, len, style;
    added = 0;
    while (added < n) begin
      style = $urandom_range(0, 9);
      g = $urandom_range(0, NGPU - 1);
      if (style < 2) begin
        // idle run: flush the window with zeros
        len = $urandom_range(WIN, WIN + 3);
        for (int i = 0; i < len; i++)
          push_sample(g, 1'b1, 0, $urandom_range(0, 3) != 0,
                      ($urandom_range(0, 2) == 0) ? 0 : rand_q16());
      end else if (style == 2) begin
        len = 1;
        push_sample(g, 1'b0, rand_q16(), $urandom_range(0, 1), rand_q16());
      end else if (style == 3) begin
        len = 1;
        push_sample(g, $urandom_range(0, 1), rand_q16(), $urandom_range(0, 1), rand_q16());
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          push_sample(g, 1'b1, rand_q16(), $urandom_range(0, 9) != 0, rand_q16());
      end
      added += len;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(int unsigned fmax, int unsigned feff, int unsigned fmin,
                            int unsigned bias);
    write_reg(CFG_FREQ_MAX, fmax[15:0]);
    write_reg(CFG_FREQ_EFF, feff[15:0]);
    write_reg(CFG_FREQ_MIN, fmin[15:0]);
    write_reg(CFG_EPB, {9'd0, bias[6:0]});
    gov_max = fmax[15:0];
    gov_eff = feff[15:0];
    gov_min = fmin[15:0];
    gov_bias = bias[6:0];
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_valid_i || pending_requests.size() != 0)
      @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_samples
    if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        pending_requests.insert(pending_requests.size(), govern_sample(in_data_i));
        samples_sent++;
        send_gap = no_idle ? 0 : $urandom_range(0, 14);
      end
      if (send_gap == 0 && sample_queue.size() != 0) begin
        in_data_i <= sample_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        if (send_gap > 0) send_gap--;
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    gfg_out_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_requests.size() == 0) begin
        if (errors < 30)
          $display("[%0t] result for GPU %0d with nothing outstanding",
                   $realtime, out_data_o.gpu_number);
        errors++;
      end else begin
        want = pending_requests.pop_front();
        report_mismatch("gpu_number", out_data_o.gpu_number, want.gpu_number);
        report_mismatch("frequency_request", out_data_o.frequency_request,
                        want.frequency_request);
        report_mismatch("write_control", out_data_o.write_control, want.write_control);
        report_mismatch("sample_class", out_data_o.sample_class, want.sample_class);
        report_mismatch("write_count", out_data_o.write_count, want.write_count);
        report_mismatch("low_count", out_data_o.low_count, want.low_count);
        report_mismatch("high_count", out_data_o.high_count, want.high_count);
        report_mismatch("sm_low_count", out_data_o.sm_low_count, want.sm_low_count);
        class_seen[want.sample_class]++;
        if (want.write_control) freq_writes_seen++;
      end
      results_seen++;
      stall_hold = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      out_stall_i <= (stall_hold > 0);
    end else if (out_valid_o && stall_hold > 0) begin
      stall_hold--;
      out_stall_i <= (stall_hold > 0);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[%0t] timeout with %0d results outstanding", $realtime,
               pending_requests.size());
      $display("** gpu_frequency_governor: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned a, b, c, tmp;
    for (int g = 0; g < NGPU; g++) begin
      for (int i = 0; i < WIN; i++) util_hist[g][i] = '0;
      hist_ptr[g] = 0;
      last_freq[g] = '0;
      freq_written[g] = 1'b0;
    end
    writes_cnt = '0;
    low_cnt = '0;
    high_cnt = '0;
    sm_low_cnt = '0;
    for (int k = 0; k < 4; k++) class_seen[k] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed samples at reset settings
    push_sample(0, 1'b0, 0, 1'b0, 0);
    push_sample(0, 1'b0, 65536, 1'b1, 65536);
    push_sample(1, 1'b1, 0, 1'b0, 0);
    push_sample(1, 1'b1, 0, 1'b1, 0);
    push_sample(1, 1'b1, 0, 1'b1, 65536);
    push_sample(1, 1'b1, 0, 1'b1, 1);
    push_sample(2, 1'b1, 65536, 1'b1, 65536);
    push_sample(2, 1'b1, 65536, 1'b0, 0);
    push_sample(2, 1'b1, 0, 1'b1, 32768);
    push_sample(2, 1'b1, 0, 1'b1, 65536);
    push_sample(3, 1'b1, 1, 1'b1, 65536);
    push_sample(3, 1'b1, 65535, 1'b1, 0);
    push_sample(3, 1'b1, 40000, 1'b1, 20000);
    for (int i = 0; i < WIN; i++) push_sample(3, 1'b1, 0, 1'b1, 0);
    push_sample(3, 1'b1, 0, 1'b1, 65535);
    push_sample(4, 1'b1, 21845, 1'b1, 10922);
    push_sample(5, 1'b1, 65536, 1'b1, 1);
    push_sample(6, 1'b1, 1, 1'b1, 1);
    push_sample(7, 1'b1, 65536, 1'b1, 12345);
    push_sample(7, 1'b1, 65536, 1'b1, 12345);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph >= 1 && ph <= 6) begin
        set_config(fix_max[ph-1], fix_eff[ph-1], fix_min[ph-1], fix_bias[ph-1]);
      end else if (ph > 6) begin
        a = $urandom_range(0, 65535);
        b = $urandom_range(0, 65535);
        c = $urandom_range(0, 65535);
        if ($urandom_range(0, 2) != 0) begin
          if (a < b) begin tmp = a; a = b; b = tmp; end
          if (b < c) begin tmp = b; b = c; c = tmp; end
          if (a < b) begin tmp = a; a = b; b = tmp; end
        end
        set_config(a, b, c, ($urandom_range(0, 4) == 0) ? $urandom_range(101, 127)
                                                       : $urandom_range(0, 100));
      end
      no_idle = (ph % 4 == 3);
      add_random_samples(RANDOM_PER_PHASE);
      wait_drained();
      phases_run++;
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d samples under %0d register settings; %0d requests checked, %0d writes.",
             samples_sent, phases_run, results_seen, freq_writes_seen);
    $display("Classes: active %0d, idle with SM %0d, idle %0d, no utilization %0d.",
             class_seen[CLS_ACTIVE], class_seen[CLS_SM_IDLE], class_seen[CLS_IDLE],
             class_seen[CLS_NO_UTIL]);
    if (errors == 0 && pending_requests.size() == 0) begin
      $display("** gpu_frequency_governor: PASSED **");
    end else begin
      $display("%0d mismatches, %0d requests never seen", errors, pending_requests.size());
      $display("** gpu_frequency_governor: FAILED **");
    end
    $finish;
  end

endmodule
